/* design/ddm_pkg.sv */
package ddm_pkg;

   localparam int PWM_BITS_DEF     = 12;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ATAN_LEN         = 24;
   localparam logic [15:0] MAX_LIN_RST = 16'd200;
   localparam logic [15:0] MAX_ANG_RST = 16'd1500;
   localparam logic [31:0] GAIN_Q30    = 32'h26DD3B6A;
   localparam logic [23:0] NRAD_TO_BA  = 24'd11468322;
   localparam logic [1:0]  CSR_MAX_LIN = 2'd0;
   localparam logic [1:0]  CSR_MAX_ANG = 2'd1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIV_LIN, ST_DIV_ANG, ST_MIX, ST_DIV_L, ST_DIV_R, ST_BRIDGE,
      ST_COR1, ST_POS_MUL, ST_POS_ACC, ST_HEAD, ST_COR2, ST_DONE
   } state_type;

   function automatic logic [31:0] atan_ba(input logic [4:0] i);
      logic [31:0] r;
      begin
         unique case (i)
            5'd0:  r = 32'h20000000; 5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B; 5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43; 5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E; 5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53; 5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
            default: r = 32'h0;
         endcase
         return r;
      end
   endfunction

endpackage

/* design/diff_drive_mixer_pwm_odometry_unit.sv */
// Differential-drive mixer, slow-decay H-bridge PWM and dead-reckoning odometry.
//
// Channels: req_* carries one control tick (linear speed, angular speed, tick_us),
// accepted when req_valid is high and req_stall low. rsp_* carries one result per
// tick (four bridge duties, x/y position in nm, heading, half-angle quaternion),
// taken when rsp_valid is high and rsp_stall low. csr_* writes register 0
// (max linear speed) or 1 (max angular speed); other indices are ignored.
//
// Datapath: one shared restoring divider (one quotient bit per cycle, four
// divisions) and one shared CORDIC stage (run twice) do the work. rsp_valid
// rises in DONE, after the second CORDIC pass; after the result transfer the
// block returns to idle. One tick at a time: req_stall stays high from accept
// until the result transfer completes.
//
// Reset clears the position and heading accumulators and loads the register
// defaults (200, 1500). A stalled result holds on rsp_* and the block takes no
// new tick until it goes.
module diff_drive_mixer_pwm_odometry_unit #(
   parameter int PWM_BITS     = ddm_pkg::PWM_BITS_DEF,
   parameter int CORDIC_STEPS = ddm_pkg::CORDIC_STEPS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [15:0]  req_linear_speed,
   input  logic signed [15:0]  req_angular_speed,
   input  logic [19:0]         req_tick_us,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [PWM_BITS-1:0] rsp_left_in1_duty,
   output logic [PWM_BITS-1:0] rsp_left_in2_duty,
   output logic [PWM_BITS-1:0] rsp_right_in1_duty,
   output logic [PWM_BITS-1:0] rsp_right_in2_duty,
   output logic signed [47:0]  rsp_pos_x_nm,
   output logic signed [47:0]  rsp_pos_y_nm,
   output logic [31:0]         rsp_heading_angle,
   output logic signed [15:0]  rsp_quat_z,
   output logic signed [15:0]  rsp_quat_w,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_data
);

   localparam logic [PWM_BITS-1:0] PWM_MAX = {PWM_BITS{1'b1}};
   localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

   ddm_pkg::state_type state_ff, state_in;

   logic [15:0] max_lin_ff, max_ang_ff;
   logic signed [15:0] lin_ff, ang_ff;
   logic [19:0] dt_ff;
   logic signed [47:0] x_ff, y_ff;
   logic [31:0] head_ff;

   // Shared divider: |num| (32b) / den (32b), sign applied at the end.
   logic [31:0] dnum_ff, dden_ff, dquo_ff;
   logic [32:0] drem_ff;
   logic        dneg_ff;
   logic [4:0]  cnt_ff;        // divider bit count and CORDIC step
   logic        div_go;
   logic signed [32:0] div_num;
   logic [31:0] div_den;
   logic signed [32:0] div_q;  // signed quotient

   logic signed [17:0] lt_ff;          // linear throttle, saturated to 16 bits
   logic signed [17:0] left_ff, right_ff;
   logic [17:0] m_ff;

   // CORDIC
   logic signed [33:0] cx_ff, cy_ff, cz_ff;
   logic        flip_ff;
   logic signed [33:0] cnx, cny, cnz, ash_x, ash_y;
   logic [31:0] cor_a;

   logic signed [35:0] d_ff;           // lin * dt
   logic signed [36:0] dw_ff;          // ang * dt
   logic signed [23:0] c22_ff, s22_ff;
   logic signed [59:0] px_ff, py_ff;   // d * c22, d * s22

   logic [PWM_BITS-1:0] l1_ff, l2_ff, r1_ff, r2_ff;
   logic signed [15:0] qz_ff, qw_ff;

   // ---------------- helpers ----------------
   function automatic logic signed [17:0] sat16(input logic signed [32:0] v);
      if (v > 33'sd32767) return 18'sd32767;
      else if (v < -33'sd32768) return -18'sd32768;
      else return 18'(v);
   endfunction

   function automatic logic [PWM_BITS-1:0] duty(input logic signed [17:0] t,
                                                 input logic sel2);
      logic [31:0] p;
      logic [PWM_BITS-1:0] r;
      begin
         p = 32'd0;
         r = PWM_MAX;
         if (t > 18'sd16 && sel2) begin
            p = 32'(PWM_MAX) * 32'(18'sd16384 - t);
            r = PWM_BITS'(p >> 14);
         end else if (t < -18'sd16 && !sel2) begin
            p = 32'(PWM_MAX) * 32'(18'sd16384 + t);
            r = PWM_BITS'(p >> 14);
         end
         return r;
      end
   endfunction

   function automatic logic signed [15:0] q15(input logic signed [33:0] v);
      logic signed [33:0] r;
      begin
         r = (v + 34'sd16384) >>> 15;
         if (r > 34'sd32767) return 16'sd32767;
         else if (r < -34'sd32768) return -16'sd32768;
         else return 16'(r);
      end
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
      if (v > 50'sh7FFFFFFFFFFF) return 48'sh7FFFFFFFFFFF;
      else if (v < -50'sh800000000000) return 48'sh800000000000;
      else return 48'(v);
   endfunction

   // ---------------- divider operands per state ----------------
   always_comb begin
      div_num = 33'sd0;
      div_den = 32'd1;
      unique case (state_ff)
         ddm_pkg::ST_DIV_LIN: begin
            div_num = 33'(lin_ff) <<< 14;
            div_den = 32'(max_lin_ff);
         end
         ddm_pkg::ST_DIV_ANG: begin
            div_num = 33'(ang_ff) <<< 14;
            div_den = 32'(max_ang_ff);
         end
         ddm_pkg::ST_DIV_L: begin
            div_num = 33'(left_ff) <<< 14;
            div_den = 32'(m_ff);
         end
         ddm_pkg::ST_DIV_R: begin
            div_num = 33'(right_ff) <<< 14;
            div_den = 32'(m_ff);
         end
         default: ;
      endcase
   end

   assign div_q = dneg_ff ? -$signed({1'b0, dquo_ff}) : $signed({1'b0, dquo_ff});

   // ---------------- CORDIC stage ----------------
   assign ash_x = cx_ff >>> cnt_ff;
   assign ash_y = cy_ff >>> cnt_ff;
   always_comb begin
      if (!cz_ff[33]) begin
         cnx = cx_ff - ash_y;
         cny = cy_ff + ash_x;
         cnz = cz_ff - 34'(ddm_pkg::atan_ba(cnt_ff));
      end else begin
         cnx = cx_ff + ash_y;
         cny = cy_ff - ash_x;
         cnz = cz_ff + 34'(ddm_pkg::atan_ba(cnt_ff));
      end
   end

   // angle to load for the next CORDIC pass
   logic [31:0] head_next;
   logic signed [63:0] dh_prod;
   assign dh_prod = 64'(dw_ff) * 64'($signed({1'b0, ddm_pkg::NRAD_TO_BA}));
   assign head_next = head_ff + 32'((dh_prod + 64'sd8388608) >>> 24);
   assign cor_a = (state_ff == ddm_pkg::ST_BRIDGE) ? head_ff : {1'b0, head_ff[31:1]};

   // ---------------- next state ----------------
   assign div_go = (cnt_ff == 5'd31);
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ddm_pkg::ST_IDLE:    if (req_valid) state_in = ddm_pkg::ST_DIV_LIN;
         ddm_pkg::ST_DIV_LIN: if (div_go) state_in = ddm_pkg::ST_DIV_ANG;
         ddm_pkg::ST_DIV_ANG: if (div_go) state_in = ddm_pkg::ST_MIX;
         ddm_pkg::ST_MIX:     state_in = ddm_pkg::ST_DIV_L;
         ddm_pkg::ST_DIV_L:   if (div_go) state_in = ddm_pkg::ST_DIV_R;
         ddm_pkg::ST_DIV_R:   if (div_go) state_in = ddm_pkg::ST_BRIDGE;
         ddm_pkg::ST_BRIDGE:  state_in = ddm_pkg::ST_COR1;
         ddm_pkg::ST_COR1:    if (cnt_ff == LAST_STEP) state_in = ddm_pkg::ST_POS_MUL;
         ddm_pkg::ST_POS_MUL: state_in = ddm_pkg::ST_POS_ACC;
         ddm_pkg::ST_POS_ACC: state_in = ddm_pkg::ST_HEAD;
         ddm_pkg::ST_HEAD:    state_in = ddm_pkg::ST_COR2;
         ddm_pkg::ST_COR2:    if (cnt_ff == LAST_STEP) state_in = ddm_pkg::ST_DONE;
         ddm_pkg::ST_DONE:    if (!rsp_stall) state_in = ddm_pkg::ST_IDLE;
         default:             state_in = ddm_pkg::ST_IDLE;
      endcase
   end

   // ---------------- outputs ----------------
   always_comb begin
      req_stall = (state_ff != ddm_pkg::ST_IDLE);
      rsp_valid = (state_ff == ddm_pkg::ST_DONE);
      csr_ready = (state_ff == ddm_pkg::ST_IDLE);
   end

   assign rsp_left_in1_duty  = l1_ff;
   assign rsp_left_in2_duty  = l2_ff;
   assign rsp_right_in1_duty = r1_ff;
   assign rsp_right_in2_duty = r2_ff;
   assign rsp_pos_x_nm       = x_ff;
   assign rsp_pos_y_nm       = y_ff;
   assign rsp_heading_angle  = head_ff;
   assign rsp_quat_z         = qz_ff;
   assign rsp_quat_w         = qw_ff;

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ddm_pkg::ST_IDLE;
         max_lin_ff <= ddm_pkg::MAX_LIN_RST;
         max_ang_ff <= ddm_pkg::MAX_ANG_RST;
         x_ff       <= '0;
         y_ff       <= '0;
         head_ff    <= '0;
         cnt_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               ddm_pkg::CSR_MAX_LIN: max_lin_ff <= csr_data;
               ddm_pkg::CSR_MAX_ANG: max_ang_ff <= csr_data;
               default: ;
            endcase
         end
         if (state_ff != state_in) cnt_ff <= '0;
         else cnt_ff <= cnt_ff + 5'd1;
         // products land at the end of POS_ACC, so the sums go in HEAD
         if (state_ff == ddm_pkg::ST_HEAD) begin
            x_ff    <= sat48(50'(x_ff) + 50'((px_ff + 60'sd2097152) >>> 22));
            y_ff    <= sat48(50'(y_ff) + 50'((py_ff + 60'sd2097152) >>> 22));
            head_ff <= head_next;
         end
      end
   end

   // ---------------- datapath ----------------
   logic [32:0] rem_sh;
   logic [31:0] num_abs;
   assign rem_sh = {drem_ff[31:0], dnum_ff[31]};
   assign num_abs = div_num[32] ? 32'(-div_num) : 32'(div_num);

   always_ff @(posedge clock) begin
      if (state_ff == ddm_pkg::ST_IDLE && req_valid) begin
         lin_ff <= req_linear_speed;
         ang_ff <= req_angular_speed;
         dt_ff  <= req_tick_us;
      end

      // restoring divider, one bit per cycle; loads on first cycle of a division
      if (cnt_ff == 5'd0) begin
         dnum_ff <= num_abs << 1;
         dden_ff <= div_den;
         dneg_ff <= div_num[32];
         drem_ff <= (33'(num_abs[31]) >= 33'(div_den)) ?
                    33'(num_abs[31]) - 33'(div_den) : 33'(num_abs[31]);
         dquo_ff <= {31'd0, 33'(num_abs[31]) >= 33'(div_den)};
      end else begin
         dnum_ff <= dnum_ff << 1;
         if (rem_sh >= {1'b0, dden_ff}) begin
            drem_ff <= rem_sh - {1'b0, dden_ff};
            dquo_ff <= {dquo_ff[30:0], 1'b1};
         end else begin
            drem_ff <= rem_sh;
            dquo_ff <= {dquo_ff[30:0], 1'b0};
         end
      end

      if (state_ff == ddm_pkg::ST_DIV_ANG && cnt_ff == 5'd0)
         lt_ff <= (max_lin_ff == 16'd0) ? 18'sd0 : sat16(div_q);
      if (state_ff == ddm_pkg::ST_MIX) begin
         logic signed [17:0] atv, l, r;
         atv = (max_ang_ff == 16'd0) ? 18'sd0 : sat16(div_q);
         l = lt_ff + atv;
         r = lt_ff - atv;
         left_ff  <= l;
         right_ff <= r;
         m_ff <= ((l < 0 ? -l : l) > (r < 0 ? -r : r)) ? 18'(l < 0 ? -l : l)
                                                        : 18'(r < 0 ? -r : r);
      end
      if (state_ff == ddm_pkg::ST_DIV_R && cnt_ff == 5'd0 && m_ff > 18'd16384)
         left_ff <= 18'(div_q);
      if (state_ff == ddm_pkg::ST_BRIDGE) begin
         logic signed [17:0] rv;
         rv = (m_ff > 18'd16384) ? 18'(div_q) : right_ff;
         l1_ff <= duty(left_ff, 1'b0);
         l2_ff <= duty(left_ff, 1'b1);
         r1_ff <= duty(rv, 1'b0);
         r2_ff <= duty(rv, 1'b1);
         d_ff  <= 36'(lin_ff) * 36'($signed({1'b0, dt_ff}));
         dw_ff <= 37'(ang_ff) * 37'($signed({1'b0, dt_ff}));
      end

      // CORDIC load on BRIDGE (full heading) and HEAD (half new heading)
      if (state_ff == ddm_pkg::ST_BRIDGE || state_ff == ddm_pkg::ST_HEAD) begin
         logic [31:0] a;
         a = (state_ff == ddm_pkg::ST_BRIDGE) ? cor_a : {1'b0, head_next[31:1]};
         if (a[31:30] == 2'd1 || a[31:30] == 2'd2) begin
            a = a - 32'h80000000;
            flip_ff <= 1'b1;
         end else begin
            flip_ff <= 1'b0;
         end
         cx_ff <= 34'($signed({1'b0, ddm_pkg::GAIN_Q30}));
         cy_ff <= '0;
         cz_ff <= 34'($signed(a));
      end else if (state_ff == ddm_pkg::ST_COR1 || state_ff == ddm_pkg::ST_COR2) begin
         cx_ff <= cnx;
         cy_ff <= cny;
         cz_ff <= cnz;
      end

      if (state_ff == ddm_pkg::ST_POS_MUL) begin
         logic signed [33:0] c, s;
         c = flip_ff ? -cx_ff : cx_ff;
         s = flip_ff ? -cy_ff : cy_ff;
         c22_ff <= 24'((c + 34'sd128) >>> 8);
         s22_ff <= 24'((s + 34'sd128) >>> 8);
      end
      if (state_ff == ddm_pkg::ST_POS_ACC) begin
         px_ff <= 60'(d_ff) * 60'(c22_ff);
         py_ff <= 60'(d_ff) * 60'(s22_ff);
      end
      // last CORDIC step: quaternion is ready as DONE starts
      if (state_ff == ddm_pkg::ST_COR2 && cnt_ff == LAST_STEP) begin
         qz_ff <= q15(flip_ff ? -cny : cny);
         qw_ff <= q15(flip_ff ? -cnx : cnx);
      end
   end

endmodule
